### hw/rtl/ptbp_pkg.sv
// shared types and constants for the per-type token bucket policer
`default_nettype none
package ptbp_pkg;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_SET     = 3'd2;
    localparam logic [2:0] KIND_STATS   = 3'd3;
    localparam logic [2:0] KIND_RESET   = 3'd4;

    localparam logic [2:0] ST_ALLOWED   = 3'd0;
    localparam logic [2:0] ST_DENIED    = 3'd1;
    localparam logic [2:0] ST_SET_DONE  = 3'd2;
    localparam logic [2:0] ST_SET_REJ   = 3'd3;
    localparam logic [2:0] ST_SET_FULL  = 3'd4;
    localparam logic [2:0] ST_STATS     = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    localparam logic [31:0] HASH_MUL1 = 32'h85eb_ca6b;
    localparam logic [31:0] HASH_MUL2 = 32'hc2b2_ae35;
    localparam int          HASH_SH1  = 16;
    localparam int          HASH_SH2  = 13;

    localparam logic [31:0] DEF_RATE_RST  = 32'd65536;
    localparam logic [15:0] DEF_BURST_RST = 16'd16;

    localparam logic REG_DEF_RATE  = 1'b0;
    localparam logic REG_DEF_BURST = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [15:0] count;
        logic [31:0] rate;
        logic [15:0] burst;
        logic [31:0] hash;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MATCH, S_MUL, S_DECIDE, S_WRITE, S_SWEEP_RD, S_SWEEP_WR, S_CLEAR
    } t_back_state;

endpackage
`default_nettype wire

### hw/rtl/ptbp_front.sv
// front end: accepts items, computes the murmur finalizer hash over stages, queues them
`default_nettype none
module ptbp_front
    import ptbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire t_item       i_item,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_avail,
    output t_item            o_item
);
    // hash stage registers
    logic        r_h1_v, r_h2_v, r_h3_v;
    t_item       r_h1, r_h2, r_h3;
    t_item       n_h1, n_h2, n_h3;

    // two-entry queue
    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;

    assign o_full  = r_h1_v | r_h2_v | r_h3_v | (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];

    always_comb begin
        n_h1      = i_item;
        n_h1.hash = i_item.key ^ (i_item.key >> HASH_SH1);
        n_h2      = r_h1;
        n_h2.hash = r_h1.hash * HASH_MUL1;
        n_h2.hash = n_h2.hash ^ (n_h2.hash >> HASH_SH2);
        n_h3      = r_h2;
        n_h3.hash = r_h2.hash * HASH_MUL2;
        n_h3.hash = n_h3.hash ^ (n_h3.hash >> HASH_SH1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_v <= 1'b0;
            r_h2_v <= 1'b0;
            r_h3_v <= 1'b0;
            r_cnt  <= 2'd0;
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
        end else begin
            r_h1_v <= i_take;
            r_h2_v <= r_h1_v;
            r_h3_v <= r_h2_v;
            if (r_h3_v) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, r_h3_v} - {1'b0, i_pop};
        end
        r_h1 <= n_h1;
        r_h2 <= n_h2;
        r_h3 <= n_h3;
        if (r_h3_v) begin
            r_q[r_wr] <= r_h3;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/ptbp_back.sv
// back end: table lookup, refill, decide and write-back; reset-all sweep
`default_nettype none
module ptbp_back
    import ptbp_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_avail,
    input  wire t_item       i_item,
    output logic             o_pop,
    input  wire logic [31:0] i_def_rate,
    input  wire logic [15:0] i_def_burst,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic             o_matched,
    output logic [31:0]      o_tokens_now,
    output logic [31:0]      o_allowed_total,
    output logic [31:0]      o_denied_total
);
    localparam int SW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = $clog2(SLOTS);
    // row: valid, key, rate, burst, tokens, last tick, allowed, denied
    localparam int EW    = 1 + 32 + 32 + 16 + 32 + 32 + 32 + 32;

    // per-way memories, one row per set
    logic [EW-1:0] r_mem [WAYS][BUCKETS];
    logic [EW-1:0] r_rdat [WAYS];

    t_back_state r_state, n_state;
    t_item       r_it;
    logic [SW-1:0] r_set, n_set;
    logic [AW:0]   r_sweep, n_sweep;
    logic [31:0]   r_tick, n_tick;
    logic [31:0]   r_dtok, n_dtok, r_dlast, n_dlast, r_dal, n_dal, r_dde, n_dde;

    // working bucket
    logic          r_hit, n_hit;
    logic [WW-1:0] r_way, n_way;
    logic [31:0]   r_rate, n_rate, r_tok, n_tok, r_last, n_last, r_al, n_al, r_de, n_de;
    logic [15:0]   r_burst, n_burst;
    logic [63:0]   r_prod;
    logic          r_free_ok, n_free_ok;
    logic [WW-1:0] r_free, n_free;

    logic          wr_en;
    logic [WW-1:0] wr_way;
    logic [SW-1:0] wr_set;
    logic [EW-1:0] wr_dat;

    logic          n_valid;
    logic [2:0]    n_status;
    logic          n_matched;
    logic [31:0]   n_otok, n_oal, n_ode;

    logic [31:0]   elapsed;
    logic [63:0]   tsum, cap;
    logic [31:0]   refilled;
    logic [31:0]   need;
    logic [32:0]   sadd;
    logic [WW-1:0] sw_way;
    logic [SW-1:0] sw_set;

    assign elapsed = r_tick - r_last;
    assign cap     = {32'd0, r_burst, 16'd0};
    assign tsum    = {32'd0, r_tok} + r_prod;
    assign need    = {r_it.count, 16'd0};
    assign sw_way  = WW'(r_sweep[AW-1:0] % WAYS);
    assign sw_set  = SW'(r_sweep[AW-1:0] / WAYS);

    always_comb begin
        if (elapsed == 32'd0) begin
            refilled = r_tok;
        end else if (tsum > cap) begin
            refilled = cap[31:0];
        end else begin
            refilled = tsum[31:0];
        end
    end

    always_comb begin
        logic [EW-1:0] e;
        n_state = r_state; n_set = r_set; n_sweep = r_sweep; n_tick = r_tick;
        n_dtok = r_dtok; n_dlast = r_dlast; n_dal = r_dal; n_dde = r_dde;
        n_hit = r_hit; n_way = r_way; n_rate = r_rate; n_tok = r_tok;
        n_last = r_last; n_al = r_al; n_de = r_de; n_burst = r_burst;
        n_free_ok = r_free_ok; n_free = r_free;
        o_pop = 1'b0; wr_en = 1'b0; wr_way = r_way; wr_set = r_set; wr_dat = '0;
        n_valid = 1'b0; n_status = ST_DONE; n_matched = 1'b0;
        n_otok = '0; n_oal = '0; n_ode = '0;
        sadd = '0;
        e = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    n_set = SW'(i_item.hash % BUCKETS);
                    priority if (i_item.kind == KIND_TICK) begin
                        n_tick = r_tick + 32'd1;
                        n_valid = 1'b1;
                    end else if (i_item.kind == KIND_RESET) begin
                        n_dtok = {i_def_burst, 16'd0};
                        n_dlast = r_tick;
                        n_sweep = '0;
                        n_state = S_SWEEP_RD;
                    end else if (i_item.kind == KIND_SET &&
                                 (i_item.rate == 32'd0 || i_item.burst == 16'd0)) begin
                        n_valid = 1'b1;
                        n_status = ST_SET_REJ;
                    end else if (i_item.kind == KIND_SET || i_item.kind == KIND_REQUEST ||
                                 i_item.kind == KIND_STATS) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: n_state = S_MATCH;
            S_MATCH: begin
                n_hit = 1'b0; n_way = '0; n_free_ok = 1'b0; n_free = '0;
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (r_rdat[w][EW-1] && r_rdat[w][EW-2 -: 32] == r_it.key) begin
                        n_hit = 1'b1; n_way = WW'(w);
                    end
                    if (!r_rdat[w][EW-1]) begin
                        n_free_ok = 1'b1; n_free = WW'(w);
                    end
                end
                if (n_hit) begin
                    e = r_rdat[n_way];
                    {n_rate, n_burst, n_tok, n_last, n_al, n_de} = e[EW-34:0];
                end else begin
                    n_rate = i_def_rate; n_burst = i_def_burst; n_tok = r_dtok;
                    n_last = r_dlast; n_al = r_dal; n_de = r_dde;
                end
                n_state = S_MUL;
            end
            S_MUL: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                if (r_it.kind == KIND_SET) begin
                    if (r_hit || r_free_ok) begin
                        wr_en = 1'b1;
                        wr_way = r_hit ? r_way : r_free;
                        wr_dat = {1'b1, r_it.key, r_it.rate, r_it.burst, r_it.burst, 16'd0,
                                  r_tick, 32'd0, 32'd0};
                        n_status = ST_SET_DONE; n_matched = 1'b1;
                        n_otok = {r_it.burst, 16'd0};
                    end else begin
                        n_status = ST_SET_FULL;
                    end
                end else begin
                    n_tok = r_tok; n_last = r_last; n_al = r_al; n_de = r_de;
                    n_status = ST_STATS;
                    if (r_it.kind == KIND_REQUEST) begin
                        n_status = ST_ALLOWED;
                        if (r_it.count != 16'd0) begin
                            n_tok = refilled;
                            if (elapsed != 32'd0) begin
                                n_last = r_tick;
                            end
                            if (refilled >= need) begin
                                n_tok = refilled - need;
                                sadd = {1'b0, r_al} + {17'd0, r_it.count};
                                n_al = sadd[32] ? 32'hffff_ffff : sadd[31:0];
                            end else begin
                                sadd = {1'b0, r_de} + {17'd0, r_it.count};
                                n_de = sadd[32] ? 32'hffff_ffff : sadd[31:0];
                                n_status = ST_DENIED;
                            end
                        end
                    end
                    n_matched = r_hit;
                    n_otok = n_tok; n_oal = n_al; n_ode = n_de;
                    if (r_hit) begin
                        wr_en = 1'b1; wr_way = r_way;
                        wr_dat = {1'b1, r_it.key, r_rate, r_burst, n_tok, n_last, n_al, n_de};
                    end else begin
                        n_dtok = n_tok; n_dlast = n_last; n_dal = n_al; n_dde = n_de;
                    end
                end
            end
            S_SWEEP_RD: begin
                n_state = S_SWEEP_WR;
            end
            S_SWEEP_WR: begin
                e = r_rdat[sw_way];
                if (e[EW-1]) begin
                    wr_en = 1'b1; wr_way = sw_way; wr_set = sw_set;
                    wr_dat = {1'b1, e[EW-2 -: 64], e[EW-66 -: 16], e[EW-66 -: 16], 16'd0,
                              r_tick, e[63:0]};
                end
                n_sweep = r_sweep + 1'b1;
                if (n_sweep == (AW+1)'(SLOTS)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_state = S_SWEEP_RD;
                end
            end
            S_CLEAR: begin
                // one slot per cycle after reset, all rows marked empty
                wr_en = 1'b1; wr_way = sw_way; wr_set = sw_set;
                n_sweep = r_sweep + 1'b1;
                if (n_sweep == (AW+1)'(SLOTS)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory read address: item set, or sweep set
    logic [SW-1:0] rd_set;
    assign rd_set = (r_state == S_SWEEP_RD) ? sw_set : r_set;

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < WAYS; w++) begin
            r_rdat[w] <= r_mem[w][rd_set];
            if (wr_en && wr_way == WW'(w)) begin
                r_mem[w][wr_set] <= wr_dat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sweep <= '0;
            r_tick  <= '0;
            r_dtok  <= {DEF_BURST_RST, 16'd0};
            r_dlast <= '0;
            r_dal   <= '0;
            r_dde   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_tick  <= n_tick;
            r_dtok  <= n_dtok;
            r_dlast <= n_dlast;
            r_dal   <= n_dal;
            r_dde   <= n_dde;
            o_valid <= n_valid;
        end
        if (o_pop) begin
            r_it <= i_item;
        end
        r_set <= n_set; r_hit <= n_hit; r_way <= n_way;
        r_rate <= n_rate; r_burst <= n_burst; r_tok <= n_tok; r_last <= n_last;
        r_al <= n_al; r_de <= n_de; r_free_ok <= n_free_ok; r_free <= n_free;
        r_prod <= {32'd0, elapsed} * {32'd0, r_rate};
        o_status <= n_status; o_matched <= n_matched; o_tokens_now <= n_otok;
        o_allowed_total <= n_oal; o_denied_total <= n_ode;
    end
endmodule
`default_nettype wire

### hw/rtl/per_type_token_bucket_policer.sv
// top level of the per-type token bucket policer
`default_nettype none
// usage:
//  - an item is a transfer at a rising edge with i_start high and o_busy low
//  - the front hashes the event type over three stages and queues it
//  - the back looks up the set-associative table, refills lazily,
//    decides and writes back, one item at a time
//  - with the back idle, tick and rejected set: result via the hash stages,
//    the queue and the output register; request, stats, set also pass the
//    read, match, multiply and decide states, a read-modify-write of a table row
//  - reset all sweeps every slot, a read state and a write state per
//    slot, then gives its result
//  - o_busy is high while a hashing stage holds an item and while the
//    queue is full, so a new transfer waits until the last one is hashed
//  - each result shows for one cycle, marked by o_done; no stall possible
//  - the user gives configuration writes on i_cfg_we at an edge only while idle; the block does not enforce it
//  - reset fills the default bucket; the back then clears the table one
//    slot a cycle, all BUCKETS*WAYS slots, and queued transfers wait for it
//  - undefined kinds give no result
module per_type_token_bucket_policer
    import ptbp_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_event_type,
    input  wire logic [15:0] i_token_count,
    input  wire logic [31:0] i_entry_rate,
    input  wire logic [15:0] i_entry_burst,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic             o_matched,
    output logic [31:0]      o_tokens_now,
    output logic [31:0]      o_allowed_total,
    output logic [31:0]      o_denied_total
);
    logic [31:0] r_def_rate;
    logic [15:0] r_def_burst;
    t_item       in_item, q_item;
    logic        front_full, q_avail, q_pop;

    assign o_busy = front_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_rate  <= DEF_RATE_RST;
            r_def_burst <= DEF_BURST_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DEF_RATE) begin
                r_def_rate <= i_cfg_data;
            end else begin
                r_def_burst <= i_cfg_data[15:0];
            end
        end
    end

    always_comb begin
        in_item.kind  = i_kind;
        in_item.key   = i_event_type;
        in_item.count = i_token_count;
        in_item.rate  = i_entry_rate;
        in_item.burst = i_entry_burst;
        in_item.hash  = '0;
    end

    ptbp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(i_start & ~o_busy), .i_item(in_item),
        .o_full(front_full), .i_pop(q_pop), .o_avail(q_avail), .o_item(q_item)
    );

    // a queued item waits while the back works; the queue holds two
    ptbp_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(q_avail), .i_item(q_item),
        .o_pop(q_pop), .i_def_rate(r_def_rate),
        .i_def_burst(r_def_burst), .o_valid(o_done), .o_status(o_status),
        .o_matched(o_matched), .o_tokens_now(o_tokens_now),
        .o_allowed_total(o_allowed_total), .o_denied_total(o_denied_total)
    );
endmodule
`default_nettype wire

### hw/rtl/ptbp_checker.sv
// port-level checker for the policer, bound to the top level
`default_nettype none
module ptbp_checker
    import ptbp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_done,
    input wire logic [2:0]  o_status,
    input wire logic        o_matched,
    input wire logic [31:0] o_tokens_now,
    input wire logic [31:0] o_allowed_total,
    input wire logic [31:0] o_denied_total
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status <= ST_DONE) else $error("bad status");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_DONE || o_status == ST_SET_REJ ||
         o_status == ST_SET_FULL)) |-> (!o_matched && o_tokens_now == 32'd0))
        else $error("nonzero fields");
    a_set_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_SET_DONE) |->
        (o_matched && o_allowed_total == 32'd0 && o_denied_total == 32'd0))
        else $error("set not fresh");
endmodule

bind per_type_token_bucket_policer ptbp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done), .o_status(o_status),
    .o_matched(o_matched), .o_tokens_now(o_tokens_now),
    .o_allowed_total(o_allowed_total), .o_denied_total(o_denied_total)
);
`default_nettype wire
